// ----- rtl/core/sx87_pkg.sv -----
// Package for the SysEx 8-to-7 codec: widths, register indexes, beat and command types.
`timescale 1ns / 1ps
package sx87_pkg;

	// raw byte counter width and the capacity register width
	localparam int COUNT_WIDTH = 16;
	localparam int CAP_WIDTH   = 16;
	localparam int CMP_WIDTH   = (COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH;

	// group geometry: seven 7-bit bytes behind one header
	localparam int GROUP_MAX = 7;
	localparam int GROUP_W   = 3;

	// configuration port
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_CODEC_MODE   = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_RAW_CAPACITY = CFG_INDEX_W'(1);
	localparam logic [CAP_WIDTH-1:0]   CAP_RESET        = CAP_WIDTH'(4096);

	// codec modes
	localparam logic MODE_PACK   = 1'b0;
	localparam logic MODE_UNPACK = 1'b1;

	// command queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       out_last;
		logic       overrun;
	} out_t;

	// one unit of work for the back end: a packed group or a single result
	typedef struct packed {
		logic                       is_group;
		logic [GROUP_MAX-1:0][6:0]  held;
		logic [GROUP_W-1:0]         cnt;
		logic [7:0]                 value;
		logic                       byte_valid;
		logic                       eom;
		logic                       overrun;
	} cmd_t;

endpackage

// ----- rtl/core/sx87_front.sv -----
// Front end: takes input beats and config writes, keeps message state, issues commands.
`timescale 1ns / 1ps
module sx87_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  sx87_pkg::in_t                       in_item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sx87_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [sx87_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                cmd_push,
	output sx87_pkg::cmd_t                      cmd,
	input  logic                                cmd_full
);

	logic                               mode_q;
	logic [sx87_pkg::CAP_WIDTH-1:0]     cap_q;
	logic [sx87_pkg::GROUP_W-1:0]       fill_q, fill_n;
	logic [6:0]                         high_q, high_n;
	logic                               hdr_wait_q, hdr_wait_n;
	logic [sx87_pkg::COUNT_WIDTH-1:0]   raw_count_q, raw_count_n;
	logic                               ovr_q, ovr_n;
	logic [sx87_pkg::GROUP_MAX-1:0][6:0] held_q;

	logic                               accept;
	logic [sx87_pkg::GROUP_W-1:0]       slot;
	logic [sx87_pkg::GROUP_W-1:0]       next_fill;
	logic                               group_done;
	logic [sx87_pkg::GROUP_MAX-1:0][6:0] held_merged;
	logic [6:0]                         high_pack;
	logic                               cap_hit;
	logic                               cfg_wr;

	assign in_ready  = !cmd_full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// group slot and fill bookkeeping
	always_comb begin
		slot = (fill_q >= sx87_pkg::GROUP_W'(sx87_pkg::GROUP_MAX)) ? '0 : fill_q;
		next_fill = slot + sx87_pkg::GROUP_W'(1);
		group_done = (next_fill == sx87_pkg::GROUP_W'(sx87_pkg::GROUP_MAX));
		held_merged = held_q;
		held_merged[slot] = in_item.data_byte[6:0];
		high_pack = high_q;
		high_pack[slot] = high_q[slot] | in_item.data_byte[7];
	end

	// capacity check; the counter limit caps the effective capacity
	assign cap_hit = (sx87_pkg::CMP_WIDTH'(raw_count_q) >= sx87_pkg::CMP_WIDTH'(cap_q))
		|| (raw_count_q == '1);

	// next message state and the command issued for this beat
	always_comb begin
		fill_n      = fill_q;
		high_n      = high_q;
		hdr_wait_n  = hdr_wait_q;
		raw_count_n = raw_count_q;
		ovr_n       = ovr_q;
		cmd_push    = 1'b0;
		cmd         = '0;
		if (accept) begin
			if (mode_q == sx87_pkg::MODE_PACK) begin
				high_n = high_pack;
				fill_n = next_fill;
				if (group_done || in_item.end_of_message) begin
					cmd_push       = 1'b1;
					cmd.is_group   = 1'b1;
					cmd.held       = held_merged;
					cmd.cnt        = next_fill;
					cmd.value      = {1'b0, high_pack};
					cmd.byte_valid = 1'b1;
					cmd.eom        = in_item.end_of_message;
					fill_n         = '0;
					high_n         = '0;
				end
			end else if (hdr_wait_q) begin
				high_n     = in_item.data_byte[6:0];
				hdr_wait_n = 1'b0;
				fill_n     = '0;
				if (in_item.end_of_message) begin
					cmd_push    = 1'b1;
					cmd.eom     = 1'b1;
					cmd.overrun = ovr_q;
				end
			end else begin
				cmd_push = 1'b1;
				cmd.eom  = in_item.end_of_message;
				if (cap_hit) begin
					ovr_n       = 1'b1;
					cmd.overrun = 1'b1;
				end else begin
					cmd.value       = {high_q[slot], in_item.data_byte[6:0]};
					cmd.byte_valid  = 1'b1;
					cmd.overrun     = ovr_q;
					raw_count_n     = raw_count_q + sx87_pkg::COUNT_WIDTH'(1);
				end
				fill_n = next_fill;
				if (group_done) begin
					fill_n     = '0;
					hdr_wait_n = 1'b1;
				end
			end
			// message end returns all message state to idle
			if (in_item.end_of_message) begin
				fill_n      = '0;
				high_n      = '0;
				hdr_wait_n  = 1'b1;
				raw_count_n = '0;
				ovr_n       = 1'b0;
			end
		end
		// a mode write also drops any partial message
		if (cfg_wr && cfg_index == sx87_pkg::REG_CODEC_MODE) begin
			fill_n      = '0;
			high_n      = '0;
			hdr_wait_n  = 1'b1;
			raw_count_n = '0;
			ovr_n       = 1'b0;
		end
	end

	// control and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= sx87_pkg::MODE_PACK;
			cap_q       <= sx87_pkg::CAP_RESET;
			fill_q      <= '0;
			high_q      <= '0;
			hdr_wait_q  <= 1'b1;
			raw_count_q <= '0;
			ovr_q       <= 1'b0;
		end else begin
			fill_q      <= fill_n;
			high_q      <= high_n;
			hdr_wait_q  <= hdr_wait_n;
			raw_count_q <= raw_count_n;
			ovr_q       <= ovr_n;
			if (cfg_wr && cfg_index == sx87_pkg::REG_CODEC_MODE) begin
				mode_q <= cfg_data[0];
			end
			if (cfg_wr && cfg_index == sx87_pkg::REG_RAW_CAPACITY) begin
				cap_q <= cfg_data[sx87_pkg::CAP_WIDTH-1:0];
			end
		end
	end

	// gathered low bits of the open group
	always_ff @(posedge clk) begin
		if (accept && mode_q == sx87_pkg::MODE_PACK) begin
			held_q[slot] <= in_item.data_byte[6:0];
		end
	end

endmodule

// ----- rtl/core/sx87_fifo.sv -----
// Command queue between the front and back ends.
`timescale 1ns / 1ps
module sx87_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sx87_pkg::cmd_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output sx87_pkg::cmd_t  head
);

	sx87_pkg::cmd_t                  mem_q [sx87_pkg::FIFO_DEPTH];
	logic [sx87_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [sx87_pkg::FIFO_PTR_W:0]   count_q;

	assign full       = (count_q == (sx87_pkg::FIFO_PTR_W+1)'(sx87_pkg::FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + sx87_pkg::FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sx87_pkg::FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (sx87_pkg::FIFO_PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (sx87_pkg::FIFO_PTR_W+1)'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/core/sx87_back.sv -----
// Back end: expands commands into output beats behind an output register.
`timescale 1ns / 1ps
module sx87_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  sx87_pkg::cmd_t  cmd,
	output logic            cmd_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output sx87_pkg::out_t  out_item
);

	sx87_pkg::cmd_t               cur_q;
	logic                         cur_valid_q;
	logic [sx87_pkg::GROUP_W-1:0] idx_q;
	logic                         out_valid_q;
	sx87_pkg::out_t               out_q;

	sx87_pkg::out_t               res;
	logic                         res_final;
	logic                         emit;
	logic                         done;
	logic [sx87_pkg::GROUP_W-1:0] byte_idx;

	// result for the current step: header, then held bytes, or a single beat
	always_comb begin
		byte_idx  = idx_q - sx87_pkg::GROUP_W'(1);
		res       = '0;
		res_final = 1'b1;
		if (!cur_q.is_group) begin
			res.out_byte   = cur_q.value;
			res.byte_valid = cur_q.byte_valid;
			res.out_last   = cur_q.eom;
			res.overrun    = cur_q.overrun;
		end else if (idx_q == '0) begin
			res.out_byte   = cur_q.value;
			res.byte_valid = 1'b1;
			res_final      = 1'b0;
		end else begin
			res.out_byte   = {1'b0, cur_q.held[byte_idx]};
			res.byte_valid = 1'b1;
			res_final      = (idx_q == cur_q.cnt);
			res.out_last   = cur_q.eom && (idx_q == cur_q.cnt);
		end
	end

	assign emit      = cur_valid_q && (!out_valid_q || out_ready);
	assign done      = emit && res_final;
	assign cmd_pop   = cmd_valid && (!cur_valid_q || done);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// sequencer control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (done) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + sx87_pkg::GROUP_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (emit) begin
			out_q <= res;
		end
	end

endmodule

// ----- rtl/core/sysex_eight_to_seven_codec.sv -----
// Top level of the streaming SysEx 8-into-7 byte codec.
// Usage:
//  Input beats (in_item: data byte plus end-of-message flag) enter on in_valid/in_ready.
//  Output beats (out_item: byte, byte_valid, out_last, overrun) leave on out_valid/out_ready.
//  Config writes on cfg_valid/cfg_ready: index 0 selects pack (0) or unpack (1) and
//  drops any partial message; index 1 sets the raw byte capacity for unpacking.
//  Other indexes are ignored. cfg_ready is always high; write only while idle.
//  A beat that produces output is written to the command queue, loaded into the back
//  end's current command register, then registered in the output register. The back
//  end emits one beat per cycle unless out_ready stalls it, so unpacking runs at one
//  beat per cycle; a packed group of n bytes gives a header beat, then n byte beats.
//  Pack beats that do not close a group make no output. A two-entry command queue sits
//  between the front and back ends; when it is full in_ready drops. A stalled receiver
//  holds the output register and backs up the queue, then the input.
//  Reset (arst_n low) clears all message state, selects pack mode, and sets capacity 4096.
`timescale 1ns / 1ps
module sysex_eight_to_seven_codec (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  sx87_pkg::in_t                    in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output sx87_pkg::out_t                   out_item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sx87_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sx87_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic           cmd_push;
	sx87_pkg::cmd_t cmd_in;
	logic           cmd_full;
	logic           cmd_pop;
	logic           head_valid;
	sx87_pkg::cmd_t head;

	sx87_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full)
	);

	sx87_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_data  (cmd_in),
		.full       (cmd_full),
		.pop        (cmd_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	sx87_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (head),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ----- rtl/core/sx87_checker.sv -----
// Port-level checks for the SysEx codec, bound to the top level.
`timescale 1ns / 1ps
module sx87_port_checks (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input sx87_pkg::out_t                   out_item,
	input logic                             cfg_valid,
	input logic                             cfg_ready
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output beat changed while stalled");

	// an empty beat carries a zero byte
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.byte_valid |-> out_item.out_byte == 8'h00)
		else $error("empty beat with nonzero byte");

	// an empty beat is either a closing beat or an overrun beat
	a_empty_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.byte_valid |-> out_item.out_last || out_item.overrun)
		else $error("empty beat neither closing nor overrun");

	// the config port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind sysex_eight_to_seven_codec sx87_port_checks u_sx87_port_checks (.*);
